// ----- design/adf_pkg.sv -----
`timescale 1ns / 1ps
package adf_pkg;

    localparam int MAX_FRACTION_DIGITS = 9;
    localparam int NORM_W = 34;
    localparam int MANT_W = 24;
    localparam int DIV_STEPS = 26;
    localparam int EXP_BIAS_ADJ = 150;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef logic signed [9:0] exp_t;

    typedef enum logic [1:0] {
        SRC_INT,
        SRC_FRAC,
        SRC_DIV,
        SRC_ADD
    } norm_src_t;

    typedef enum logic [1:0] {
        TGT_FI,
        TGT_FA,
        TGT_Q,
        TGT_RES
    } store_tgt_t;

    typedef struct packed {
        logic       start;
        logic       acc_int;
        logic       acc_frac;
        logic       norm_load;
        norm_src_t  norm_src;
        logic       store;
        store_tgt_t store_tgt;
        logic       q_clear;
        logic       div_init;
        logic       div_step;
        logic       res_direct;
        logic       out_err;
        logic       out_val;
    } adf_cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_term;
        logic is_point;
        logic is_minus;
        logic frac_full;
        logic frac_zero;
        logic norm_done;
        logic div_last;
        logic fi_zero;
        logic q_zero;
    } adf_sts_t;

    // Normalized significand of 10^n, with the MSB at bit 23.
    function automatic logic [MANT_W-1:0] pow10_mant(input logic [3:0] n);
        logic [MANT_W-1:0] m;
        unique case (n)
            4'd0: m = 24'd8388608;
            4'd1: m = 24'd10485760;
            4'd2: m = 24'd13107200;
            4'd3: m = 24'd16384000;
            4'd4: m = 24'd10240000;
            4'd5: m = 24'd12800000;
            4'd6: m = 24'd16000000;
            4'd7: m = 24'd10000000;
            4'd8: m = 24'd12500000;
            4'd9: m = 24'd15625000;
            default: m = 24'd8388608;
        endcase
        return m;
    endfunction

    function automatic exp_t pow10_exp(input logic [3:0] n);
        exp_t e;
        unique case (n)
            4'd0: e = -10'sd23;
            4'd1: e = -10'sd20;
            4'd2: e = -10'sd17;
            4'd3: e = -10'sd14;
            4'd4: e = -10'sd10;
            4'd5: e = -10'sd7;
            4'd6: e = -10'sd4;
            4'd7: e = 10'sd0;
            4'd8: e = 10'sd3;
            4'd9: e = 10'sd6;
            default: e = -10'sd23;
        endcase
        return e;
    endfunction

endpackage

// ----- design/ascii_decimal_to_float32.sv -----
`timescale 1ns / 1ps
// ASCII decimal to single-precision float converter.
// Input channel (s_): one character per transaction; s_tdata[7:0] is the
// character, s_tuser[0] marks the first character of a new value. A value is
// an optional minus, digits, and an optional point with up to nine fraction
// digits, ended by a space or NUL.
// Output channel (m_): one transaction per value or per error; m_tdata holds
// the IEEE-754 single bits, m_tuser[0] is 1 for a malformed value (data zero).
// Characters are taken one per cycle while a value is parsed and the output
// register is free. An error leaves on the next cycle. A terminator starts
// the conversion: an integer normalize; with a fraction, a normalize of it
// and, if it is nonzero, a long division and another normalize; then, if
// both parts are nonzero, an aligned add with its normalize. The normalizer
// shifts one bit per cycle and the divider is a restoring one. No characters
// are taken during the conversion.
// One finished result waits in the output register; s_tready stays low while
// it waits, and a finished conversion holds until the register is free.
// Reset (aresetn low, synchronous) empties the output and skips characters
// until the next start mark.
module ascii_decimal_to_float32 import adf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] float_bits
    output logic [0:0]  m_tuser    // [0] status
);

    adf_cmd_t cmd;
    adf_sts_t sts;
    logic     status;

    adf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .start_req (s_tuser[0]),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    adf_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ch         (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .float_bits (m_tdata),
        .status     (status)
    );

    assign m_tuser[0] = status;

endmodule

// ----- design/adf_dp.sv -----
`timescale 1ns / 1ps
module adf_dp import adf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  ch,
    input  adf_cmd_t    cmd,
    output adf_sts_t    sts,
    output logic [31:0] float_bits,
    output logic        status
);

    logic              neg_reg, neg_next;
    logic [31:0]       int_reg, int_next;
    logic [29:0]       frac_reg, frac_next;
    logic [3:0]        digits_reg, digits_next;

    logic [NORM_W-1:0] nv_reg;
    exp_t              ne_reg;
    logic              nst_reg, nz_reg;

    logic [MANT_W-1:0] fi_m_reg, fa_m_reg, q_m_reg, res_m_reg;
    exp_t              fi_e_reg, fa_e_reg, q_e_reg, res_e_reg;
    logic              fi_z_reg, q_z_reg, res_z_reg;

    logic [DIV_STEPS-1:0] dq_reg;
    logic [MANT_W:0]      dr_reg;
    logic [4:0]           dcnt_reg;

    logic [31:0] fb_reg;
    logic        st_reg;

    logic [3:0]  dig;
    logic [31:0] int_base;
    logic [29:0] frac_base;

    // Rounding of the normalizer word.
    logic [MANT_W-1:0] rnd_m;
    exp_t              rnd_e;
    logic              rnd_up;
    logic [MANT_W:0]   rnd_sum;

    // Alignment for the add.
    logic              fi_big;
    logic [MANT_W-1:0] big_m, sml_m;
    exp_t              big_e, sml_e, diff_e;
    logic [MANT_W+2:0] sml_ext, sml_sh, sh_mask;
    logic              sml_st;
    logic [MANT_W+3:0] add_sum;

    // Division step.
    logic [MANT_W-1:0] div_b;
    logic              div_bit;
    logic [MANT_W:0]   div_rem;

    logic [NORM_W-1:0] ld_v;
    exp_t              ld_e;
    logic              ld_st, ld_z;

    logic [9:0] biased;

    assign dig = ch[3:0];

    always_comb begin
        sts.is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        sts.is_term   = (ch == CH_SPACE) || (ch == CH_NUL);
        sts.is_point  = (ch == CH_POINT);
        sts.is_minus  = (ch == CH_MINUS);
        sts.frac_full = (digits_reg >= 4'(MAX_FRACTION_DIGITS));
        sts.frac_zero = (frac_reg == '0);
        sts.norm_done = nv_reg[NORM_W-1];
        sts.div_last  = (dcnt_reg == 5'(DIV_STEPS - 1));
        sts.fi_zero   = fi_z_reg;
        sts.q_zero    = q_z_reg;
    end

    always_comb begin
        int_base    = cmd.start ? '0 : int_reg;
        frac_base   = cmd.start ? '0 : frac_reg;
        neg_next    = cmd.start ? sts.is_minus : neg_reg;
        int_next    = int_base;
        frac_next   = frac_base;
        digits_next = cmd.start ? '0 : digits_reg;
        if (cmd.acc_int) begin
            int_next = (int_base << 3) + (int_base << 1) + {28'd0, dig};
        end
        if (cmd.acc_frac) begin
            frac_next   = (frac_base << 3) + (frac_base << 1) + {26'd0, dig};
            digits_next = digits_next + 4'd1;
        end
    end

    always_comb begin
        rnd_up  = nv_reg[9] && ((|nv_reg[8:0]) || nst_reg || nv_reg[10]);
        rnd_sum = {1'b0, nv_reg[NORM_W-1:10]} + {{MANT_W{1'b0}}, rnd_up};
        if (rnd_sum[MANT_W]) begin
            rnd_m = rnd_sum[MANT_W:1];
            rnd_e = ne_reg + exp_t'(11);
        end else begin
            rnd_m = rnd_sum[MANT_W-1:0];
            rnd_e = ne_reg + exp_t'(10);
        end
    end

    always_comb begin
        fi_big  = (fi_e_reg >= q_e_reg);
        big_m   = fi_big ? fi_m_reg : q_m_reg;
        big_e   = fi_big ? fi_e_reg : q_e_reg;
        sml_m   = fi_big ? q_m_reg : fi_m_reg;
        sml_e   = fi_big ? q_e_reg : fi_e_reg;
        diff_e  = big_e - sml_e;
        sml_ext = {sml_m, 3'b000};
        sh_mask = ~({(MANT_W+3){1'b1}} << diff_e[4:0]);
        if (diff_e >= exp_t'(MANT_W + 3)) begin
            sml_sh = '0;
            sml_st = |sml_m;
        end else begin
            sml_sh = sml_ext >> diff_e[4:0];
            sml_st = |(sml_ext & sh_mask);
        end
        add_sum = {1'b0, big_m, 3'b000} + {1'b0, sml_sh};
    end

    always_comb begin
        div_b   = pow10_mant(digits_reg);
        div_bit = (dr_reg >= {1'b0, div_b});
        div_rem = div_bit ? (dr_reg - {1'b0, div_b}) : dr_reg;
    end

    always_comb begin
        ld_z  = 1'b0;
        ld_st = 1'b0;
        unique case (cmd.norm_src)
            SRC_INT: begin
                ld_v = {2'b00, int_reg};
                ld_e = '0;
                ld_z = (int_reg == '0);
            end
            SRC_FRAC: begin
                ld_v = {4'b0000, frac_reg};
                ld_e = '0;
                ld_z = (frac_reg == '0);
            end
            SRC_DIV: begin
                ld_v  = {dq_reg, 8'd0};
                ld_e  = fa_e_reg - pow10_exp(digits_reg) - exp_t'(DIV_STEPS - 1 + 8);
                ld_st = (dr_reg != '0);
            end
            SRC_ADD: begin
                ld_v  = {add_sum, 6'd0};
                ld_e  = big_e - exp_t'(9);
                ld_st = sml_st;
            end
            default: begin
                ld_v = '0;
                ld_e = '0;
            end
        endcase
        // A zero value is parked in normalized form so the shift loop stops.
        if (ld_z) begin
            ld_v = {1'b1, {(NORM_W-1){1'b0}}};
        end
    end

    assign biased = 10'(res_e_reg + exp_t'(EXP_BIAS_ADJ));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_reg    <= 1'b0;
            int_reg    <= '0;
            frac_reg   <= '0;
            digits_reg <= '0;
            fi_z_reg   <= 1'b1;
            q_z_reg    <= 1'b1;
            res_z_reg  <= 1'b1;
            dcnt_reg   <= '0;
        end else begin
            neg_reg    <= neg_next;
            int_reg    <= int_next;
            frac_reg   <= frac_next;
            digits_reg <= digits_next;
            if (cmd.q_clear) begin
                q_z_reg <= 1'b1;
            end
            if (cmd.div_init) begin
                dcnt_reg <= '0;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + 5'd1;
            end
            if (cmd.store) begin
                unique case (cmd.store_tgt)
                    TGT_FI:  fi_z_reg  <= nz_reg;
                    TGT_FA:  ;
                    TGT_Q:   q_z_reg   <= nz_reg;
                    TGT_RES: res_z_reg <= nz_reg;
                    default: ;
                endcase
            end else if (cmd.res_direct) begin
                res_z_reg <= fi_z_reg && q_z_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.norm_load) begin
            nv_reg  <= ld_v;
            ne_reg  <= ld_e;
            nst_reg <= ld_st;
            nz_reg  <= ld_z;
        end else if (!nv_reg[NORM_W-1]) begin
            nv_reg <= nv_reg << 1;
            ne_reg <= ne_reg - exp_t'(1);
        end

        if (cmd.store) begin
            unique case (cmd.store_tgt)
                TGT_FI: begin
                    fi_m_reg <= rnd_m;
                    fi_e_reg <= rnd_e;
                end
                TGT_FA: begin
                    fa_m_reg <= rnd_m;
                    fa_e_reg <= rnd_e;
                end
                TGT_Q: begin
                    q_m_reg <= rnd_m;
                    q_e_reg <= rnd_e;
                end
                TGT_RES: begin
                    res_m_reg <= rnd_m;
                    res_e_reg <= rnd_e;
                end
                default: ;
            endcase
        end else if (cmd.res_direct) begin
            // One operand is zero, so the sum is the other one exactly.
            res_m_reg <= fi_z_reg ? q_m_reg : fi_m_reg;
            res_e_reg <= fi_z_reg ? q_e_reg : fi_e_reg;
        end

        if (cmd.div_init) begin
            dq_reg <= '0;
            dr_reg <= {1'b0, fa_m_reg};
        end else if (cmd.div_step) begin
            dq_reg <= {dq_reg[DIV_STEPS-2:0], div_bit};
            dr_reg <= {div_rem[MANT_W-1:0], 1'b0};
        end

        if (cmd.out_err) begin
            fb_reg <= '0;
            st_reg <= 1'b1;
        end else if (cmd.out_val) begin
            fb_reg <= res_z_reg ? {neg_reg, 31'd0} : {neg_reg, biased[7:0], res_m_reg[22:0]};
            st_reg <= 1'b0;
        end
    end

    assign float_bits = fb_reg;
    assign status     = st_reg;

endmodule

// ----- design/adf_ctrl.sv -----
`timescale 1ns / 1ps
module adf_ctrl import adf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     start_req,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  adf_sts_t sts,
    output adf_cmd_t cmd
);

    typedef enum logic [14:0] {
        ST_SKIP  = 15'b000000000000001,
        ST_NEED  = 15'b000000000000010,
        ST_INT   = 15'b000000000000100,
        ST_FRAC  = 15'b000000000001000,
        ST_CINT  = 15'b000000000010000,
        ST_WINT  = 15'b000000000100000,
        ST_CFRAC = 15'b000000001000000,
        ST_WFRAC = 15'b000000010000000,
        ST_CDIV  = 15'b000000100000000,
        ST_DIV   = 15'b000001000000000,
        ST_CDIVN = 15'b000010000000000,
        ST_WDIV  = 15'b000100000000000,
        ST_CADD  = 15'b001000000000000,
        ST_WADD  = 15'b010000000000000,
        ST_OUT   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next, phase_eff;
    logic   has_frac_reg, has_frac_next;
    logic   out_valid_reg, out_valid_next;
    logic   parse_state, out_free, acc_in;

    assign parse_state = (state_reg == ST_SKIP) || (state_reg == ST_NEED) ||
                         (state_reg == ST_INT) || (state_reg == ST_FRAC);
    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = parse_state && out_free;
    assign acc_in      = s_tvalid && s_tready;
    assign m_tvalid    = out_valid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        has_frac_next = has_frac_reg;
        phase_eff     = start_req ? ST_NEED : state_reg;

        unique case (state_reg)
            ST_SKIP, ST_NEED, ST_INT, ST_FRAC: begin
                if (acc_in) begin
                    if (start_req) begin
                        cmd.start     = 1'b1;
                        has_frac_next = 1'b0;
                    end
                    if (start_req && sts.is_minus) begin
                        state_next = ST_NEED;
                    end else begin
                        unique case (phase_eff)
                            ST_NEED: begin
                                if (sts.is_digit) begin
                                    cmd.acc_int = 1'b1;
                                    state_next  = ST_INT;
                                end else begin
                                    cmd.out_err = 1'b1;
                                    state_next  = ST_SKIP;
                                end
                            end
                            ST_INT: begin
                                priority if (sts.is_digit) begin
                                    cmd.acc_int = 1'b1;
                                end else if (sts.is_point) begin
                                    has_frac_next = 1'b1;
                                    state_next    = ST_FRAC;
                                end else if (sts.is_term) begin
                                    state_next = ST_CINT;
                                end else begin
                                    cmd.out_err = 1'b1;
                                    state_next  = ST_SKIP;
                                end
                            end
                            ST_FRAC: begin
                                priority if (sts.is_digit && !sts.frac_full) begin
                                    cmd.acc_frac = 1'b1;
                                end else if (sts.is_term) begin
                                    state_next = ST_CINT;
                                end else begin
                                    cmd.out_err = 1'b1;
                                    state_next  = ST_SKIP;
                                end
                            end
                            default: state_next = ST_SKIP;
                        endcase
                    end
                end
            end
            ST_CINT: begin
                cmd.norm_load = 1'b1;
                cmd.norm_src  = SRC_INT;
                cmd.q_clear   = 1'b1;
                state_next    = ST_WINT;
            end
            ST_WINT: begin
                if (sts.norm_done) begin
                    cmd.store     = 1'b1;
                    cmd.store_tgt = TGT_FI;
                    state_next    = has_frac_reg ? ST_CFRAC : ST_CADD;
                end
            end
            ST_CFRAC: begin
                cmd.norm_load = 1'b1;
                cmd.norm_src  = SRC_FRAC;
                state_next    = ST_WFRAC;
            end
            ST_WFRAC: begin
                if (sts.norm_done) begin
                    cmd.store     = 1'b1;
                    cmd.store_tgt = TGT_FA;
                    state_next    = sts.frac_zero ? ST_CADD : ST_CDIV;
                end
            end
            ST_CDIV: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_CDIVN;
                end
            end
            ST_CDIVN: begin
                cmd.norm_load = 1'b1;
                cmd.norm_src  = SRC_DIV;
                state_next    = ST_WDIV;
            end
            ST_WDIV: begin
                if (sts.norm_done) begin
                    cmd.store     = 1'b1;
                    cmd.store_tgt = TGT_Q;
                    state_next    = ST_CADD;
                end
            end
            ST_CADD: begin
                if (sts.fi_zero || sts.q_zero) begin
                    cmd.res_direct = 1'b1;
                    state_next     = ST_OUT;
                end else begin
                    cmd.norm_load = 1'b1;
                    cmd.norm_src  = SRC_ADD;
                    state_next    = ST_WADD;
                end
            end
            ST_WADD: begin
                if (sts.norm_done) begin
                    cmd.store     = 1'b1;
                    cmd.store_tgt = TGT_RES;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_val = 1'b1;
                    state_next  = ST_SKIP;
                end
            end
            default: state_next = ST_SKIP;
        endcase
    end

    always_comb begin
        if (cmd.out_err || cmd.out_val) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SKIP;
            has_frac_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            has_frac_reg  <= has_frac_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_ready_only_parsing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> parse_state)
        else $error("input ready outside the parse states");
    a_no_output_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_err || cmd.out_val) |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten before it was taken");
    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_CDIVN))
        else $error("division did not hand over to the normalizer");
`endif

endmodule
